// ===== rtl/itda_pkg.sv =====
// Shared types, constants and the control store for the decimal ASCII converter.
// Used by the sequencer, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package itda_pkg;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned BCD_DIGITS = 20;
	localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
	localparam int unsigned DIGIT_CW   = $clog2(BCD_DIGITS + 1);
	localparam int unsigned BIT_CW     = $clog2(VALUE_W);
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned MAX_LEN    = 21;
	localparam int unsigned STEP_W     = 3;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef struct packed {
		logic [VALUE_W-1:0] value_bits;
		logic               is_signed;
	} in_t;

	typedef struct packed {
		logic [7:0]       character;
		logic [LEN_W-1:0] text_length;
		logic             is_last;
	} out_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_CONV,
		OP_TRIM,
		OP_EMIT_SIGN,
		OP_EMIT_DIGIT
	} op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_BITS_DONE,
		COND_TRIM_DONE,
		COND_SIGN_DONE,
		COND_LAST_DIGIT
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_LOAD  = 3'd0;
	localparam step_t STEP_CONV  = 3'd1;
	localparam step_t STEP_TRIM  = 3'd2;
	localparam step_t STEP_SIGN  = 3'd3;
	localparam step_t STEP_DIGIT = 3'd4;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic bits_done;
		logic trim_done;
		logic sign_done;
		logic last_digit;
	} status_t;

	function automatic ctrl_t rom_word(input step_t step);
		ctrl_t w;
		case (step)
			STEP_LOAD:  w = '{op: OP_LOAD,       cond: COND_IN_VALID,   jmp: STEP_CONV};
			STEP_CONV:  w = '{op: OP_CONV,       cond: COND_BITS_DONE,  jmp: STEP_TRIM};
			STEP_TRIM:  w = '{op: OP_TRIM,       cond: COND_TRIM_DONE,  jmp: STEP_SIGN};
			STEP_SIGN:  w = '{op: OP_EMIT_SIGN,  cond: COND_SIGN_DONE,  jmp: STEP_DIGIT};
			STEP_DIGIT: w = '{op: OP_EMIT_DIGIT, cond: COND_LAST_DIGIT, jmp: STEP_LOAD};
			default:    w = '{op: OP_NOP,        cond: COND_ALWAYS,     jmp: STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/itda_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on itda_pkg for the control word, status and step definitions.
`timescale 1ns / 1ps

module itda_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  itda_pkg::status_t status,
	output itda_pkg::ctrl_t   ctrl
);

	itda_pkg::step_t pc_q;
	logic            take;

	assign ctrl = itda_pkg::rom_word(pc_q);

	always_comb begin
		case (ctrl.cond)
			itda_pkg::COND_ALWAYS:     take = 1'b1;
			itda_pkg::COND_IN_VALID:   take = status.in_valid;
			itda_pkg::COND_BITS_DONE:  take = status.bits_done;
			itda_pkg::COND_TRIM_DONE:  take = status.trim_done;
			itda_pkg::COND_SIGN_DONE:  take = status.sign_done;
			itda_pkg::COND_LAST_DIGIT: take = status.last_digit;
			default:                   take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= itda_pkg::STEP_LOAD;
		end else if (take) begin
			pc_q <= ctrl.jmp;
		end
	end

endmodule

// ===== rtl/integer_to_decimal_ascii.sv =====
// Top level of the 64-bit integer to decimal ASCII converter: datapath and output register.
// Depends on itda_pkg and the microcode sequencer itda_seq.
//
// Channel   Direction  Handshake               Payload
// in        request    in_valid / in_ready     in_data  (value_bits, is_signed)
// out       result     out_valid / out_ready   out_data (character, text_length, is_last)
//
// A request passes through a load step, shift-add-3 over all 64 input bits,
// stripping of leading zeros, a sign step and the emission of the digits, most
// significant first. Only one request is in work at a time.
// A stalled output holds the sequencer on its current emit step.
// Reset returns the sequencer to its load step and empties the output register.
`timescale 1ns / 1ps

module integer_to_decimal_ascii (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  itda_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output itda_pkg::out_t out_data
);

	itda_pkg::ctrl_t   ctrl;
	itda_pkg::status_t status;

	logic [itda_pkg::VALUE_W-1:0]  mag_q;
	logic [itda_pkg::BCD_W-1:0]    bcd_q;
	logic [itda_pkg::BCD_W-1:0]    adj;
	logic [itda_pkg::BIT_CW-1:0]   cnt_q;
	logic [itda_pkg::DIGIT_CW-1:0] digits_q;
	logic [itda_pkg::LEN_W-1:0]    len_q;
	logic                          neg_q;
	logic                          out_valid_q;
	itda_pkg::out_t                out_q;

	logic       out_free;
	logic       load_neg;
	logic [3:0] top_digit;
	logic       trim_done;
	logic       emit_sign;
	logic       emit_digit;

	itda_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_ready  = (ctrl.op == itda_pkg::OP_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign out_free   = !out_valid_q || out_ready;
	assign load_neg   = in_data.is_signed && in_data.value_bits[itda_pkg::VALUE_W-1];
	assign top_digit  = bcd_q[itda_pkg::BCD_W-1 -: 4];
	assign trim_done  = (top_digit != 4'd0) || (digits_q == itda_pkg::DIGIT_CW'(1));
	assign emit_sign  = (ctrl.op == itda_pkg::OP_EMIT_SIGN) && neg_q && out_free;
	assign emit_digit = (ctrl.op == itda_pkg::OP_EMIT_DIGIT) && out_free;

	assign status.in_valid   = in_valid;
	assign status.bits_done  = (cnt_q == {itda_pkg::BIT_CW{1'b1}});
	assign status.trim_done  = trim_done;
	assign status.sign_done  = !neg_q || out_free;
	assign status.last_digit = out_free && (digits_q == itda_pkg::DIGIT_CW'(1));

	// Each digit of 5 or more gets 3 added before the doubling shift.
	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < itda_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == itda_pkg::OP_LOAD && in_valid) begin
				neg_q <= load_neg;
			end
			if (emit_sign || emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			itda_pkg::OP_LOAD: begin
				mag_q    <= load_neg ? (~in_data.value_bits + 64'd1) : in_data.value_bits;
				bcd_q    <= '0;
				cnt_q    <= '0;
				digits_q <= itda_pkg::DIGIT_CW'(itda_pkg::BCD_DIGITS);
			end
			itda_pkg::OP_CONV: begin
				bcd_q <= {adj[itda_pkg::BCD_W-2:0], mag_q[itda_pkg::VALUE_W-1]};
				mag_q <= {mag_q[itda_pkg::VALUE_W-2:0], 1'b0};
				cnt_q <= cnt_q + itda_pkg::BIT_CW'(1);
			end
			itda_pkg::OP_TRIM: begin
				if (trim_done) begin
					len_q <= itda_pkg::LEN_W'(digits_q) + itda_pkg::LEN_W'(neg_q);
				end else begin
					bcd_q    <= {bcd_q[itda_pkg::BCD_W-5:0], 4'd0};
					digits_q <= digits_q - itda_pkg::DIGIT_CW'(1);
				end
			end
			itda_pkg::OP_EMIT_SIGN: begin
				if (emit_sign) begin
					out_q.character   <= itda_pkg::ASCII_MINUS;
					out_q.text_length <= len_q;
					out_q.is_last     <= 1'b0;
				end
			end
			itda_pkg::OP_EMIT_DIGIT: begin
				if (emit_digit) begin
					out_q.character   <= itda_pkg::ASCII_ZERO + {4'd0, top_digit};
					out_q.text_length <= len_q;
					out_q.is_last     <= (digits_q == itda_pkg::DIGIT_CW'(1));
					bcd_q             <= {bcd_q[itda_pkg::BCD_W-5:0], 4'd0};
					digits_q          <= digits_q - itda_pkg::DIGIT_CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/itda_checker.sv =====
// Port-level checker for the decimal ASCII converter, bound to the top level.
// Depends on itda_pkg for the character and length constants.
`timescale 1ns / 1ps

module itda_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input itda_pkg::out_t out_data
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only one request is converted at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one is in work");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.character == itda_pkg::ASCII_MINUS ||
			(out_data.character >= itda_pkg::ASCII_ZERO &&
			 out_data.character <= itda_pkg::ASCII_NINE))
		else $error("result character outside sign and digits");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.text_length >= 5'd1 &&
			out_data.text_length <= 5'(itda_pkg::MAX_LEN))
		else $error("text length out of range");

	// The sign always precedes at least one digit.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.character == itda_pkg::ASCII_MINUS |->
			!out_data.is_last && out_data.text_length >= 5'd2)
		else $error("sign character ends a run");

endmodule

bind integer_to_decimal_ascii itda_checker u_itda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
